@@ sv/vrya_pkg.sv @@
// shared types and constants for the visible-range vertical autoscale block
// no dependencies; used by every other file of the block
`default_nettype none

package vrya_pkg;

   // action codes
   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // record formats
   localparam logic [1:0] FMT_POINT   = 2'd0;
   localparam logic [1:0] FMT_CANDLE  = 2'd1;
   localparam logic [1:0] FMT_RECT    = 2'd2;
   localparam logic [1:0] FMT_UNKNOWN = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_LOW        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_HIGH       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCLUDE_ZERO = 2'd3;

   // configuration reset values
   localparam logic signed [31:0] X_LOW_RESET  = 32'sh8000_0000;
   localparam logic signed [31:0] X_HIGH_RESET = 32'sh7FFF_FFFF;
   localparam logic [15:0]        MARGIN_RESET = 16'd205;

   // running state reset values
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   // widened bound limits for saturation
   localparam logic signed [37:0] WIDE_MAX = 38'sh0_7FFF_FFFF;
   localparam logic signed [37:0] WIDE_MIN = -38'sh0_8000_0000;

   // margin fraction is Q4.12
   localparam int unsigned MARGIN_FRAC_BITS = 12;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef struct packed {
      logic              action;
      logic [1:0]        record_format;
      logic signed [31:0] word_zero;
      logic signed [31:0] word_one;
      logic signed [31:0] word_two;
      logic signed [31:0] word_three;
   } req_payload_type;

   typedef struct packed {
      logic              range_found;
      logic signed [31:0] y_min;
      logic signed [31:0] y_max;
   } rsp_payload_type;

   // classified item: a visible record or a finish
   typedef struct packed {
      logic              finish;
      logic signed [31:0] rec_low;
      logic signed [31:0] rec_high;
   } entry_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [15:0] margin_fraction;
      logic        include_zero;
   } back_cfg_type;

endpackage

`default_nettype wire

@@ sv/vrya_front.sv @@
// front end: visibility test and low/high extraction for one record
// depends on vrya_pkg
`default_nettype none

module vrya_front (
   input  wire vrya_pkg::req_payload_type item,
   input  wire logic signed [31:0]        visible_x_low,
   input  wire logic signed [31:0]        visible_x_high,
   output vrya_pkg::entry_type            entry,
   output logic                           keep
);

   logic signed [32:0] pos;
   logic signed [32:0] edge_lo;
   logic signed [32:0] edge_hi;
   logic               known;
   logic               visible;

   always_comb begin
      pos           = 33'(item.word_zero);
      edge_lo       = 33'(visible_x_low);
      edge_hi       = 33'(visible_x_high);
      known         = 1'b1;
      entry.finish  = (item.action == vrya_pkg::ACT_FINISH);
      entry.rec_low  = item.word_one;
      entry.rec_high = item.word_one;
      unique case (item.record_format)
         vrya_pkg::FMT_POINT: begin
         end
         vrya_pkg::FMT_CANDLE: begin
            entry.rec_low  = item.word_three;
            entry.rec_high = item.word_two;
         end
         vrya_pkg::FMT_RECT: begin
            // compare doubled midpoint against doubled edges
            pos     = 33'(item.word_zero) + 33'(item.word_two);
            edge_lo = {visible_x_low, 1'b0};
            edge_hi = {visible_x_high, 1'b0};
            if (item.word_one < item.word_three) begin
               entry.rec_low  = item.word_one;
               entry.rec_high = item.word_three;
            end else begin
               entry.rec_low  = item.word_three;
               entry.rec_high = item.word_one;
            end
         end
         vrya_pkg::FMT_UNKNOWN: begin
            known = 1'b0;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      visible = !(pos < edge_lo) && !(pos > edge_hi);
      keep    = entry.finish || (known && visible);
   end

endmodule

`default_nettype wire

@@ sv/vrya_queue.sv @@
// short queue of classified items between front and back
// depends on vrya_pkg
`default_nettype none

module vrya_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire vrya_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     pop_valid,
   output vrya_pkg::entry_type      pop_entry
);

   vrya_pkg::entry_type mem_ff [vrya_pkg::QUEUE_DEPTH];
   logic [vrya_pkg::QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [vrya_pkg::QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [vrya_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == vrya_pkg::QUEUE_CNT_W'(vrya_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[head_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      head_in  = do_pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = do_push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ sv/vrya_back.sv @@
// back end: running low/high accumulation and the three-stage finish pipeline
// depends on vrya_pkg
`default_nettype none

module vrya_back #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire vrya_pkg::back_cfg_type  cfg,
   input  wire logic                    q_valid,
   input  wire vrya_pkg::entry_type     q_entry,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output vrya_pkg::rsp_payload_type    rsp_payload
);

   localparam logic [31:0] ONE_SPAN = 32'd1 << FRAC_BITS;

   logic signed [31:0] low_ff, low_in;
   logic signed [31:0] high_ff, high_in;
   logic               seen_ff, seen_in;

   // stage 1: snapshot of the state at finish
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_seen_ff;
   logic signed [31:0] s1_low_ff;
   logic signed [31:0] s1_high_ff;
   // stage 2: span times margin fraction
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_seen_ff;
   logic signed [31:0] s2_low_ff;
   logic signed [31:0] s2_high_ff;
   logic [47:0]        s2_prod_ff;
   // output register
   logic                      out_valid_ff, out_valid_in;
   vrya_pkg::rsp_payload_type out_ff, out_in;

   logic               out_ready;
   logic               s2_ready;
   logic               s1_ready;
   logic               take_finish;
   logic signed [32:0] span_wide;
   logic [31:0]        span;
   logic [47:0]        prod;
   logic signed [37:0] margin;
   logic signed [37:0] lo_wide;
   logic signed [37:0] hi_wide;

   function automatic logic [35:0] prod_shift(input logic [47:0] p);
      prod_shift = p[47:vrya_pkg::MARGIN_FRAC_BITS];
   endfunction

   function automatic logic signed [31:0] sat_value(input logic signed [37:0] v);
      if (v > vrya_pkg::WIDE_MAX) begin
         sat_value = vrya_pkg::VALUE_MAX;
      end else if (v < vrya_pkg::WIDE_MIN) begin
         sat_value = vrya_pkg::VALUE_MIN;
      end else begin
         sat_value = v[31:0];
      end
   endfunction

   assign out_ready   = !out_valid_ff || !rsp_stall;
   assign s2_ready    = !s2_valid_ff || out_ready;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign q_pop       = q_valid && (!q_entry.finish || s1_ready);
   assign take_finish = q_pop && q_entry.finish;

   // running state
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      seen_in = seen_ff;
      if (take_finish) begin
         low_in  = vrya_pkg::VALUE_MAX;
         high_in = vrya_pkg::VALUE_MIN;
         seen_in = 1'b0;
      end else if (q_pop) begin
         if (q_entry.rec_low < low_ff) begin
            low_in = q_entry.rec_low;
         end
         if (q_entry.rec_high > high_ff) begin
            high_in = q_entry.rec_high;
         end
         seen_in = 1'b1;
      end
   end

   // span and margin product
   always_comb begin
      span_wide = 33'(s1_high_ff) - 33'(s1_low_ff);
      if (span_wide[32] || (span_wide == '0)) begin
         span = ONE_SPAN;
      end else begin
         span = span_wide[31:0];
      end
      prod = 48'(span) * 48'(cfg.margin_fraction);
   end

   // widened bounds, include zero, saturate
   always_comb begin
      margin  = 38'(prod_shift(s2_prod_ff));
      lo_wide = 38'(s2_low_ff) - margin;
      hi_wide = 38'(s2_high_ff) + margin;
      if (cfg.include_zero) begin
         if (lo_wide > 38'sd0) begin
            lo_wide = '0;
         end
         if (hi_wide < 38'sd0) begin
            hi_wide = '0;
         end
      end
      out_in.range_found = s2_seen_ff;
      if (!s2_seen_ff) begin
         out_in.y_min = '0;
         out_in.y_max = '0;
      end else begin
         out_in.y_min = sat_value(lo_wide);
         out_in.y_max = sat_value(hi_wide);
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = s2_valid_ff;
      end
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
      if (s1_ready) begin
         s1_valid_in = take_finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= vrya_pkg::VALUE_MAX;
         high_ff      <= vrya_pkg::VALUE_MIN;
         seen_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         seen_ff      <= seen_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && take_finish) begin
         s1_seen_ff <= seen_ff;
         s1_low_ff  <= low_ff;
         s1_high_ff <= high_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_seen_ff <= s1_seen_ff;
         s2_low_ff  <= s1_low_ff;
         s2_high_ff <= s1_high_ff;
         s2_prod_ff <= prod;
      end
      if (out_ready && s2_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

@@ sv/visible_range_y_autoscale.sv @@
// top level of the visible-range vertical autoscale block
// depends on vrya_pkg, vrya_front, vrya_queue and vrya_back
`default_nettype none

// Takes one chart record (point, candle or rectangle) or one finish command per
// cycle while req_stall is low. Records whose horizontal position lies inside
// [visible_x_low, visible_x_high] widen a running low/high; a finish returns
// one result with the found flag and the range widened on each side by
// margin_fraction (Q4.12) times the span, optionally pulled to include zero and
// saturated to 32 bits, then clears the running state. Throughput is one item
// per cycle while the queue is not full: the front classifies a record in the
// cycle it is accepted and writes it into a four-entry queue, and the back
// folds one queued item per cycle into the running low/high while no finish is
// held at the queue head. A finish leaves the queue into a three-stage pipeline
// (snapshot, 32x16 span multiply, widen/saturate into the output register). A
// stalled result only holds back further finishes; records keep flowing until
// the queue fills, and req_stall is high exactly while the queue is full.
// Configuration is written through csr_ while the block is idle; a write to
// index 0..3 takes effect on the next cycle.

module visible_range_y_autoscale #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire vrya_pkg::req_payload_type           req_payload,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output vrya_pkg::rsp_payload_type                rsp_payload,
   // configuration write port
   input  wire logic                                csr_write,
   input  wire logic [vrya_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [vrya_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic signed [31:0] x_low_ff;
   logic signed [31:0] x_high_ff;
   logic [15:0]        margin_ff;
   logic               include_zero_ff;

   // front to queue
   vrya_pkg::entry_type front_entry;
   logic                front_keep;
   logic                queue_full;
   // queue to back
   logic                q_valid;
   logic                q_pop;
   vrya_pkg::entry_type q_entry;
   vrya_pkg::back_cfg_type back_cfg;

   // register writes, reset to the documented defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff        <= vrya_pkg::X_LOW_RESET;
         x_high_ff       <= vrya_pkg::X_HIGH_RESET;
         margin_ff       <= vrya_pkg::MARGIN_RESET;
         include_zero_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            vrya_pkg::CSR_X_LOW:        x_low_ff        <= csr_wdata;
            vrya_pkg::CSR_X_HIGH:       x_high_ff       <= csr_wdata;
            vrya_pkg::CSR_MARGIN:       margin_ff       <= csr_wdata[15:0];
            vrya_pkg::CSR_INCLUDE_ZERO: include_zero_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // classify the incoming record; dropped records never enter the queue
   vrya_front u_front (
      .item           (req_payload),
      .visible_x_low  (x_low_ff),
      .visible_x_high (x_high_ff),
      .entry          (front_entry),
      .keep           (front_keep)
   );

   assign req_stall = queue_full;

   // decouples classification from accumulation and result back-pressure
   vrya_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && front_keep),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   assign back_cfg.margin_fraction = margin_ff;
   assign back_cfg.include_zero    = include_zero_ff;

   // running range and finish pipeline
   vrya_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (back_cfg),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ sv/vrya_checker.sv @@
// port-level checks for the visible-range vertical autoscale block
// depends on vrya_pkg; bound to visible_range_y_autoscale
`default_nettype none

module vrya_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire vrya_pkg::req_payload_type req_payload,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire vrya_pkg::rsp_payload_type rsp_payload
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty range reports zero bounds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.range_found |->
         rsp_payload.y_min == 32'sd0 && rsp_payload.y_max == 32'sd0)
      else $error("empty range with nonzero bounds");

   // a stalled request holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("request changed while stalled");

endmodule

bind visible_range_y_autoscale vrya_checker u_vrya_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

@@ test/tb_visible_range_y_autoscale.sv @@
`timescale 1ns / 1ps
// testbench for visible_range_y_autoscale: directed and random chart records with a
// self-contained range predictor; depends on vrya_pkg and the block's top level only

module tb_visible_range_y_autoscale;

   localparam int FRAC_BITS = 16;
   localparam int ONE       = 1 << FRAC_BITS;   // 1.0 in Q16.16
   localparam int ITEMS_PER_PHASE = 215;

   // clock, reset and block ports; every input starts at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vrya_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vrya_pkg::rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [vrya_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [vrya_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // idle rates in percent for the two sides
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // predictor copy of the registers and the running range
   logic signed [31:0] x_low_cfg;
   logic signed [31:0] x_high_cfg;
   logic [15:0] margin_cfg;
   logic zero_cfg;
   logic signed [31:0] run_low;
   logic signed [31:0] run_high;
   logic range_seen;

   // ranges still owed by the block, oldest first
   vrya_pkg::rsp_payload_type expected_ranges[$];
   int unsigned fault_count = 0;

   visible_range_y_autoscale DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // widen the running range with one data record if its position is visible
   task automatic fold_record(input vrya_pkg::req_payload_type item);
      logic signed [33:0] pos;
      logic signed [33:0] lo_edge;
      logic signed [33:0] hi_edge;
      logic signed [31:0] rec_low;
      logic signed [31:0] rec_high;
      case (item.record_format)
         vrya_pkg::FMT_POINT: begin
            pos = item.word_zero;
            lo_edge = x_low_cfg;
            hi_edge = x_high_cfg;
            rec_low = item.word_one;
            rec_high = item.word_one;
         end
         vrya_pkg::FMT_CANDLE: begin
            pos = item.word_zero;
            lo_edge = x_low_cfg;
            hi_edge = x_high_cfg;
            rec_low = item.word_three;
            rec_high = item.word_two;
         end
         vrya_pkg::FMT_RECT: begin
            // twice the midpoint against twice the edges, so nothing is rounded
            pos = item.word_zero + item.word_two;
            lo_edge = x_low_cfg * 2;
            hi_edge = x_high_cfg * 2;
            rec_low = (item.word_one < item.word_three) ? item.word_one : item.word_three;
            rec_high = (item.word_one > item.word_three) ? item.word_one : item.word_three;
         end
         default: return;   // unknown format is skipped
      endcase
      if (pos < lo_edge || pos > hi_edge) return;
      if (rec_low < run_low) run_low = rec_low;
      if (rec_high > run_high) run_high = rec_high;
      range_seen = 1'b1;
   endtask

   // report the widened range for a finish and clear the running state
   function automatic vrya_pkg::rsp_payload_type close_range();
      vrya_pkg::rsp_payload_type result;
      longint span;
      longint margin;
      longint lo;
      longint hi;
      result = '0;
      if (range_seen) begin
         span = longint'(run_high) - longint'(run_low);
         if (span <= 0) span = longint'(1) << FRAC_BITS;   // flat range counts as 1.0
         margin = (span * longint'(margin_cfg)) >>> vrya_pkg::MARGIN_FRAC_BITS;
         lo = longint'(run_low) - margin;
         hi = longint'(run_high) + margin;
         if (zero_cfg) begin
            if (lo > 0) lo = 0;
            if (hi < 0) hi = 0;
         end
         if (lo < longint'(vrya_pkg::VALUE_MIN)) lo = vrya_pkg::VALUE_MIN;
         if (hi > longint'(vrya_pkg::VALUE_MAX)) hi = vrya_pkg::VALUE_MAX;
         result.range_found = 1'b1;
         result.y_min = lo[31:0];
         result.y_max = hi[31:0];
      end
      run_low = vrya_pkg::VALUE_MAX;
      run_high = vrya_pkg::VALUE_MIN;
      range_seen = 1'b0;
      return result;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // one transfer on the input channel; returns at the falling edge after it,
   // with valid left high so that a following item can go back to back
   task automatic send_item(input vrya_pkg::req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      if (item.action == vrya_pkg::ACT_FINISH) begin
         expected_ranges.push_back(close_range());
      end else begin
         fold_record(item);
      end
      @(negedge clock);
   endtask

   // sender pause: drop valid, wait for every owed range, then let queued records drain
   task automatic wait_for_ranges();
      req_valid <= 1'b0;
      while (expected_ranges.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // drive one register write; write enable is left high for the caller to drop
   task automatic write_reg(input logic [vrya_pkg::CSR_INDEX_W-1:0] index,
                            input logic [vrya_pkg::CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         vrya_pkg::CSR_X_LOW:        x_low_cfg = data;
         vrya_pkg::CSR_X_HIGH:       x_high_cfg = data;
         vrya_pkg::CSR_MARGIN:       margin_cfg = data[15:0];
         vrya_pkg::CSR_INCLUDE_ZERO: zero_cfg = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // write all four registers; only called while the block is idle
   task automatic apply_settings(input logic signed [31:0] x_low,
                                 input logic signed [31:0] x_high,
                                 input logic [15:0] margin, input logic with_zero);
      write_reg(vrya_pkg::CSR_X_LOW, x_low);
      write_reg(vrya_pkg::CSR_X_HIGH, x_high);
      // unused upper bits carry noise, the block must ignore them
      write_reg(vrya_pkg::CSR_MARGIN, {16'($urandom), margin});
      write_reg(vrya_pkg::CSR_INCLUDE_ZERO, {31'($urandom), with_zero});
      csr_write <= 1'b0;
   endtask

   function automatic vrya_pkg::req_payload_type make_item(input logic action,
         input logic [1:0] fmt,
         input logic signed [31:0] w0, input logic signed [31:0] w1,
         input logic signed [31:0] w2, input logic signed [31:0] w3);
      vrya_pkg::req_payload_type item;
      item.action = action;
      item.record_format = fmt;
      item.word_zero = w0;
      item.word_one = w1;
      item.word_two = w2;
      item.word_three = w3;
      return item;
   endfunction

   // value words: extremes, full random and a moderate band so spans stay in range
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return vrya_pkg::VALUE_MIN;
         1: return vrya_pkg::VALUE_MAX;
         2: return '0;
         3, 4, 5: return $urandom;
         default: return int'($urandom_range(2_000_000)) - 1_000_000;
      endcase
   endfunction

   // horizontal position, biased toward the visible window and its edges
   function automatic logic signed [31:0] pick_position();
      longint lo;
      longint hi;
      longint p;
      longint unsigned r;
      lo = x_low_cfg;
      hi = x_high_cfg;
      if (lo > hi) return $urandom;
      r = {$urandom, $urandom};
      case ($urandom_range(7))
         0: p = lo;
         1: p = hi;
         2: p = lo - 1;
         3: p = hi + 1;
         default: p = lo + longint'(r % longint'(hi - lo + 1));
      endcase
      if (p < longint'(vrya_pkg::VALUE_MIN) || p > longint'(vrya_pkg::VALUE_MAX)) p = lo;
      return p[31:0];
   endfunction

   // ------------------------------------------------------------------
   // result side: random stall and checking
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // each result transfer is matched against the oldest owed range
   always @(posedge clock) begin : check_ranges
      vrya_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ranges.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: result with none owed: found=%0b y_min=%0d y_max=%0d",
                        $realtime, rsp_payload.range_found, rsp_payload.y_min,
                        rsp_payload.y_max);
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_payload.range_found !== want.range_found ||
                rsp_payload.y_min !== want.y_min || rsp_payload.y_max !== want.y_max) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"%0t: range mismatch: expected found=%0b y_min=%0d y_max=%0d,",
                            " got found=%0b y_min=%0d y_max=%0d"},
                           $realtime, want.range_found, want.y_min, want.y_max,
                           rsp_payload.range_found, rsp_payload.y_min, rsp_payload.y_max);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset settings: empty finish, saturation, candle, unknown format, edge rect, flat range
   task automatic test_empty_and_extremes();
      // nothing seen
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_POINT, 0, 0, 0, 0));
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, 0,
                          vrya_pkg::VALUE_MIN, 0, 0));
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, vrya_pkg::VALUE_MAX,
                          vrya_pkg::VALUE_MAX, 0, 0));
      // saturates both ways
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_UNKNOWN, -1, -1, -1, -1));
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_CANDLE, vrya_pkg::VALUE_MIN,
                          0, 100 * ONE, -5 * ONE));
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_UNKNOWN, 0,
                          vrya_pkg::VALUE_MIN, vrya_pkg::VALUE_MAX, vrya_pkg::VALUE_MIN));
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_CANDLE, 0, 0, 0, 0));
      // rectangle whose midpoint sits exactly on the left reset edge
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_RECT, vrya_pkg::VALUE_MIN,
                          3 * ONE, vrya_pkg::VALUE_MIN, -ONE));
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_RECT, 0, 0, 0, 0));
      // single value, zero span widened as if it were 1.0
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, -1, 7 * ONE, 0, 0));
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_POINT, 0, 0, 0, 0));
      wait_for_ranges();
   endtask

   // window [-10, 10], no margin, zero pulled in; positions on and beyond the edges
   task automatic test_edges_and_include_zero();
      apply_settings(-10 * ONE, 10 * ONE, 16'd0, 1'b1);
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, -10 * ONE, 5 * ONE,
                          0, 0));
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, -10 * ONE - 1,
                          vrya_pkg::VALUE_MIN, 0, 0));
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, 10 * ONE + 1,
                          vrya_pkg::VALUE_MAX, 0, 0));
      // midpoint half an lsb past the right edge
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_RECT, 10 * ONE,
                          vrya_pkg::VALUE_MIN, 10 * ONE + 1, 0));
      // midpoint exactly on the right edge
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_RECT, 10 * ONE - 3, 8 * ONE,
                          10 * ONE + 3, 6 * ONE));
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_POINT, 0, 0, 0, 0));
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_CANDLE, 0, 0, -3 * ONE,
                          -9 * ONE));
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_POINT, 0, 0, 0, 0));
      wait_for_ranges();
   endtask

   // reversed window hides everything; one-point window with the largest margin
   task automatic test_window_and_margin();
      apply_settings(1, -1, 16'hFFFF, 1'b0);
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, 0, ONE, 0, 0));
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_POINT, 0, 0, 0, 0));
      wait_for_ranges();
      apply_settings(0, 0, 16'hFFFF, 1'b0);
      send_item(make_item(vrya_pkg::ACT_RECORD, vrya_pkg::FMT_POINT, 0, -ONE, 0, 0));
      send_item(make_item(vrya_pkg::ACT_FINISH, vrya_pkg::FMT_POINT, 0, 0, 0, 0));
      wait_for_ranges();
   endtask

   // two random phases under one idle pattern; each phase picks its own settings
   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned recv_pct,
                                      input int unsigned first_phase);
      vrya_pkg::req_payload_type item;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] pos;
      longint d;
      longint w0;
      longint w2;
      int unsigned sent;
      int unsigned n_rec;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int unsigned phase = first_phase; phase < first_phase + 2; phase++) begin
         wait_for_ranges();
         a = $urandom;
         b = $urandom;
         case (phase % 4)
            0: apply_settings(vrya_pkg::VALUE_MIN, vrya_pkg::VALUE_MAX, 16'hFFFF, 1'b1);
            1: begin
               pos = int'($urandom_range(20 * ONE)) - 10 * ONE;
               apply_settings(pos, pos + int'($urandom_range(4 * ONE)), 16'd0, 1'b0);
            end
            2: begin
               // sorted random window, now and then left reversed
               if ((a > b) && ($urandom_range(7) != 0))
                  apply_settings(b, a, 16'($urandom), 1'($urandom));
               else
                  apply_settings(a, b, 16'($urandom), 1'($urandom));
            end
            default: apply_settings(vrya_pkg::VALUE_MIN, vrya_pkg::VALUE_MAX,
                                    vrya_pkg::MARGIN_RESET, 1'($urandom));
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            // a frame of records closed by a finish; mostly short, sometimes long or empty
            n_rec = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
            for (int unsigned i = 0; i < n_rec; i++) begin
               item = make_item(vrya_pkg::ACT_RECORD, 2'($urandom_range(2)), 0,
                                pick_value(), pick_value(), pick_value());
               if ($urandom_range(99) < 12) begin
                  // noise: any format, any position
                  item.record_format = 2'($urandom);
                  item.word_zero = $urandom;
                  item.word_two = $urandom;
               end else begin
                  pos = pick_position();
                  item.word_zero = pos;
                  if (item.record_format == vrya_pkg::FMT_RECT) begin
                     // spread around the midpoint, off by half an lsb at times
                     d = int'($urandom_range(2000)) - 1000;
                     w0 = longint'(pos) - d;
                     w2 = longint'(pos) + d + (int'($urandom_range(2)) - 1);
                     if (w0 < longint'(vrya_pkg::VALUE_MIN) ||
                         w0 > longint'(vrya_pkg::VALUE_MAX) ||
                         w2 < longint'(vrya_pkg::VALUE_MIN) ||
                         w2 > longint'(vrya_pkg::VALUE_MAX)) begin
                        w0 = pos;
                        w2 = pos;
                     end
                     item.word_zero = w0[31:0];
                     item.word_two = w2[31:0];
                  end
               end
               send_item(item);
               if (item.record_format != vrya_pkg::FMT_UNKNOWN) sent++;
            end
            send_item(make_item(vrya_pkg::ACT_FINISH, 2'($urandom), $urandom, $urandom,
                                $urandom, $urandom));
            sent++;
         end
      end
      wait_for_ranges();
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      // predictor starts from the reset state
      x_low_cfg = vrya_pkg::X_LOW_RESET;
      x_high_cfg = vrya_pkg::X_HIGH_RESET;
      margin_cfg = vrya_pkg::MARGIN_RESET;
      zero_cfg = 1'b0;
      run_low = vrya_pkg::VALUE_MAX;
      run_high = vrya_pkg::VALUE_MIN;
      range_seen = 1'b0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 56;
      test_empty_and_extremes();
      test_edges_and_include_zero();
      test_window_and_margin();

      test_random_traffic(16, 56, 0);
      test_random_traffic(56, 16, 2);
      test_random_traffic(0, 0, 4);

      // every owed range has arrived and queued records have drained
      wait_for_ranges();
      if (fault_count == 0 && expected_ranges.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
